// File: hw/rtl/kca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kca_pkg: shared constants and types for the keypad click/autorepeat block
// Key table, field widths, reset values and register indexes.
// ----------------------------------------------------------------------------
package kca_pkg;

  localparam int unsigned NumKeys  = 12;
  localparam int unsigned KeyWordW = 16;
  localparam int unsigned KeyIdxW  = 4;
  localparam int unsigned TickInW  = 32;
  localparam int unsigned TickBits = 32;  // width of the wrapping time compare
  localparam int unsigned DelayW   = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [KeyWordW-1:0] KeysReleased      = '1;
  localparam logic [DelayW-1:0]   FirstDelayReset   = 16'd500;
  localparam logic [DelayW-1:0]   RepeatDelayReset  = 16'd175;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgFirstDelay  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatDelay = 2'd1;

  // key masks, table order; entry i is key index i+1
  localparam logic [KeyWordW-1:0] KeyMask [NumKeys] = '{
    16'h0080, 16'h0040, 16'h0010, 16'h0020, 16'h0100, 16'h0003,
    16'h0001, 16'h0004, 16'h0008, 16'h0400, 16'h0200, 16'h0800
  };

  typedef logic [KeyIdxW-1:0] key_idx_t;

  // decode result handed to the repeat logic
  typedef struct packed {
    logic [NumKeys-1:0] pmask;
    key_idx_t           pkey;
    key_idx_t           ckey;
  } dec_t;

endpackage
`default_nettype wire

// File: hw/rtl/kca_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kca_decode: key table decode
// Pressed mask, first pressed key and first newly clicked key of one scan.
// ----------------------------------------------------------------------------
module kca_decode
  import kca_pkg::*;
(
  input  var logic [KeyWordW-1:0] cur_keys_i,
  input  var logic [KeyWordW-1:0] prev_keys_i,
  output dec_t                    dec_o
);

  logic [NumKeys-1:0] cur_down;
  logic [NumKeys-1:0] click;

  always_comb begin
    for (int i = 0; i < NumKeys; i++) begin
      cur_down[i] = ((cur_keys_i & KeyMask[i]) == '0);
      click[i]    = cur_down[i] && ((prev_keys_i & KeyMask[i]) != '0);
    end
  end

  // priority encode, lowest table entry wins
  always_comb begin
    dec_o.pmask = cur_down;
    dec_o.pkey  = '0;
    dec_o.ckey  = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (cur_down[i]) begin
        dec_o.pkey = KeyIdxW'(i + 1);
      end
      if (click[i]) begin
        dec_o.ckey = KeyIdxW'(i + 1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/kca_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kca_repeat: autorepeat tracker
// Remembers the held key and its last event time, fires clicks and repeats.
// ----------------------------------------------------------------------------
module kca_repeat
  import kca_pkg::*;
(
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                step_i,
  input  var logic                clear_i,
  input  var logic [TickBits-1:0] now_i,
  input  var dec_t                dec_i,
  input  var logic [DelayW-1:0]   first_delay_i,
  input  var logic [DelayW-1:0]   repeat_delay_i,
  output key_idx_t                repeat_key_o
);

  key_idx_t            held_q, held_d;
  logic [TickBits-1:0] event_q, event_d;
  logic                rep_q, rep_d;

  key_idx_t            held_eff;
  logic                held_down;
  logic [TickBits-1:0] elapsed;
  logic [DelayW-1:0]   limit;

  always_comb begin
    held_eff  = clear_i ? '0 : held_q;
    held_down = 1'b0;
    for (int i = 0; i < NumKeys; i++) begin
      if (held_eff == KeyIdxW'(i + 1)) begin
        held_down = dec_i.pmask[i];
      end
    end
    elapsed = now_i - event_q;  // wraps modulo 2^TickBits
    limit   = rep_q ? repeat_delay_i : first_delay_i;

    held_d       = held_q;
    event_d      = event_q;
    rep_d        = rep_q;
    repeat_key_o = '0;
    if (dec_i.ckey != '0) begin
      held_d       = dec_i.ckey;
      rep_d        = 1'b0;
      event_d      = now_i;
      repeat_key_o = dec_i.ckey;
    end else if (held_down) begin
      held_d = held_eff;
      if (elapsed > TickBits'(limit)) begin
        rep_d        = 1'b1;
        event_d      = now_i;
        repeat_key_o = held_eff;
      end
    end else begin
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      event_q <= '0;
      rep_q   <= 1'b0;
    end else if (step_i) begin
      held_q  <= held_d;
      event_q <= event_d;
      rep_q   <= rep_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/keypad_click_autorepeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_click_autorepeat: keypad scan decoder with click and autorepeat
// Decodes twelve table keys from an active-low scan word and reports
// pressed keys, new clicks and timed autorepeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one scan per transfer:
//   raw_keys_i (bit 0 = pressed), tick_now_i and clear_repeat_i.
//   Output channel (out_valid_o / out_stall_i) returns one result per scan:
//   pressed_mask_o, pressed_key_o, clicked_key_o and repeat_key_o.
//   Configuration writes (cfg_valid_i / cfg_ready_o) set first_delay (index 0)
//   and repeat_delay (index 1); other indexes are ignored. cfg_ready_o is
//   always high; write only while no scan is in flight.
// Timing:
//   A scan is captured in the input register on the input transfer and
//   then moves into the result register, which drives the outputs.
//   One scan per cycle is sustained while the output is not stalled; the
//   whole decode and repeat decision sits between those two registers.
// Reset:
//   Previous key word resets to all released, no held key, event time zero,
//   delays back to 500 and 175 ticks. Both pipeline stages come up empty.
// Stall:
//   A stalled result holds; the input register still takes a scan while the
//   result register is full, and in_stall_o rises only once both are full.
// ----------------------------------------------------------------------------
module keypad_click_autorepeat
  import kca_pkg::*;
(
  input  var logic                clk_i,
  input  var logic                rst_ni,
  // scan input
  input  var logic                in_valid_i,
  output logic                    in_stall_o,
  input  var logic [KeyWordW-1:0] raw_keys_i,
  input  var logic [TickInW-1:0]  tick_now_i,
  input  var logic                clear_repeat_i,
  // result output
  output logic                    out_valid_o,
  input  var logic                out_stall_i,
  output logic [NumKeys-1:0]      pressed_mask_o,
  output logic [KeyIdxW-1:0]      pressed_key_o,
  output logic [KeyIdxW-1:0]      clicked_key_o,
  output logic [KeyIdxW-1:0]      repeat_key_o,
  // configuration writes
  input  var logic                cfg_valid_i,
  output logic                    cfg_ready_o,
  input  var logic [CfgIdxW-1:0]  cfg_index_i,
  input  var logic [DelayW-1:0]   cfg_data_i
);

  // --- configuration registers ----------------------------------------------
  logic [DelayW-1:0] first_delay_q;
  logic [DelayW-1:0] repeat_delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q  <= FirstDelayReset;
      repeat_delay_q <= RepeatDelayReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgFirstDelay:  first_delay_q  <= cfg_data_i;
        CfgRepeatDelay: repeat_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --- pipeline control -----------------------------------------------------
  // s1 = input register, result register drives the output ports.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;   // result register can take a new result this cycle
  logic step;       // s1 moves into the result register
  logic in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // --- input register -------------------------------------------------------
  logic [KeyWordW-1:0] s1_keys_q;
  logic [TickBits-1:0] s1_now_q;
  logic                s1_clear_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_keys_q  <= raw_keys_i;
      s1_now_q   <= TickBits'(tick_now_i);
      s1_clear_q <= clear_repeat_i;
    end
  end

  // --- previous scan word ---------------------------------------------------
  // The current word is the scan in s1; the previous word is the last one
  // that went through.
  logic [KeyWordW-1:0] prev_keys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q <= KeysReleased;
    end else if (step) begin
      prev_keys_q <= s1_keys_q;
    end
  end

  // --- decode and autorepeat ------------------------------------------------
  dec_t     dec;
  key_idx_t rep_key;

  kca_decode u_decode (
    .cur_keys_i  (s1_keys_q),
    .prev_keys_i (prev_keys_q),
    .dec_o       (dec)
  );

  kca_repeat u_repeat (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .clear_i        (s1_clear_q),
    .now_i          (s1_now_q),
    .dec_i          (dec),
    .first_delay_i  (first_delay_q),
    .repeat_delay_i (repeat_delay_q),
    .repeat_key_o   (rep_key)
  );

  // --- result register ------------------------------------------------------
  logic [NumKeys-1:0] pmask_q;
  key_idx_t           pkey_q;
  key_idx_t           ckey_q;
  key_idx_t           rkey_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      pmask_q <= dec.pmask;
      pkey_q  <= dec.pkey;
      ckey_q  <= dec.ckey;
      rkey_q  <= rep_key;
    end
  end

  assign pressed_mask_o = pmask_q;
  assign pressed_key_o  = pkey_q;
  assign clicked_key_o  = ckey_q;
  assign repeat_key_o   = rkey_q;

endmodule
`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for keypad_click_autorepeat
// Drives key scans with random idling and stalls on both channels and keeps
// its own copy of the key decode and autorepeat timer. Each result is checked
// field by field against the oldest predicted result. Runs through directed
// decode and timing cases, then random key sessions under several delay
// settings, a no-idle stretch and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import kca_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned IdlePct    = 18;    // chance of an idle cycle, per cent
  localparam int unsigned HoldCycles = 60;    // long receiver hold-off
  localparam int unsigned DrainWait  = 8;     // margin after the last result comes back

  // indexes past the two real registers; the block must ignore them
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam key_idx_t NoKey = '0;

  typedef struct packed {
    logic [NumKeys-1:0] pmask;
    key_idx_t           pkey;
    key_idx_t           ckey;
    key_idx_t           rkey;
  } scan_res_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic [KeyWordW-1:0] raw_keys_i     = KeysReleased;
  logic [TickInW-1:0]  tick_now_i     = '0;
  logic                clear_repeat_i = 1'b0;
  logic                out_stall_i    = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = CfgFirstDelay;
  logic [DelayW-1:0]   cfg_data_i     = '0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [NumKeys-1:0]  pressed_mask_o;
  logic [KeyIdxW-1:0]  pressed_key_o;
  logic [KeyIdxW-1:0]  clicked_key_o;
  logic [KeyIdxW-1:0]  repeat_key_o;
  logic                cfg_ready_o;

  always #5 clk_i = ~clk_i;

  keypad_click_autorepeat DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_keys_i     (raw_keys_i),
    .tick_now_i     (tick_now_i),
    .clear_repeat_i (clear_repeat_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pressed_mask_o (pressed_mask_o),
    .pressed_key_o  (pressed_key_o),
    .clicked_key_o  (clicked_key_o),
    .repeat_key_o   (repeat_key_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the key words, repeat timer and delays,
  // starting from the reset values
  // --------------------------------------------------------------------------
  logic [KeyWordW-1:0] cur_word        = KeysReleased;
  logic [KeyWordW-1:0] prev_word       = KeysReleased;
  key_idx_t            held_idx        = NoKey;
  logic [TickBits-1:0] last_event_tick = '0;
  logic                in_repeat       = 1'b0;
  logic [DelayW-1:0]   first_dly       = FirstDelayReset;
  logic [DelayW-1:0]   repeat_dly      = RepeatDelayReset;

  scan_res_t pending_results[$];

  // run bookkeeping
  int unsigned fail_count   = 0;
  int unsigned scans_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned clicks_seen  = 0;
  int unsigned repeats_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_count  = 0;

  // stimulus knobs
  logic                idle_on   = 1'b1;   // sender gaps
  logic                stall_on  = 1'b1;   // receiver stalls
  logic                hold_tog  = 1'b0;   // toggled to request a long hold-off
  logic                hold_ack  = 1'b0;
  int unsigned         hold_left = 0;
  logic [TickInW-1:0]  tick_base = '0;

  // Decode one scan and advance the repeat timer; returns the expected result.
  function automatic scan_res_t decode_scan(input logic [KeyWordW-1:0] keys,
                                            input logic [TickInW-1:0]  tick,
                                            input logic                clr);
    scan_res_t           res;
    logic [TickBits-1:0] now;
    logic [TickBits-1:0] elapsed;
    logic [DelayW-1:0]   cmp_limit;
    int                  i;
    res = '0;
    now = tick[TickBits-1:0];
    // clear is applied ahead of everything, so a click in the same scan wins
    if (clr)
      held_idx = NoKey;
    prev_word = cur_word;
    cur_word  = keys;
    for (i = 0; i < NumKeys; i++) begin
      if ((cur_word & KeyMask[i]) == '0) begin
        res.pmask[i] = 1'b1;
        if (res.pkey == NoKey)
          res.pkey = key_idx_t'(i + 1);
        // newly clicked: some masked bit was still high last scan
        if (res.ckey == NoKey && (prev_word & KeyMask[i]) != '0)
          res.ckey = key_idx_t'(i + 1);
      end
    end
    if (res.ckey != NoKey) begin
      held_idx        = res.ckey;
      in_repeat       = 1'b0;
      last_event_tick = now;
      res.rkey        = res.ckey;
    end else if (held_idx != NoKey && held_idx <= NumKeys &&
                 (cur_word & KeyMask[held_idx - 1]) == '0) begin
      // wrapping difference, strictly greater than the active delay
      elapsed   = now - last_event_tick;
      cmp_limit = in_repeat ? repeat_dly : first_dly;
      if (elapsed > cmp_limit) begin
        in_repeat       = 1'b1;
        last_event_tick = now;
        res.rkey        = held_idx;
      end
    end else begin
      held_idx = NoKey;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input monitor: every accepted scan gets its expected result queued
  // --------------------------------------------------------------------------
  scan_res_t fresh;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fresh = decode_scan(raw_keys_i, tick_now_i, clear_repeat_i);
      pending_results.push_back(fresh);
      scans_taken++;
      if (fresh.ckey != NoKey)
        clicks_seen++;
      if (fresh.rkey != NoKey && fresh.ckey == NoKey)
        repeats_seen++;
    end
  end

  // Register write monitor; writes only happen with nothing in flight
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      reg_writes++;
      case (cfg_index_i)
        CfgFirstDelay:  first_dly  = cfg_data_i;
        CfgRepeatDelay: repeat_dly = cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each transfer against the oldest expectation
  // --------------------------------------------------------------------------
  scan_res_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: pressed_mask %h pressed_key %0d clicked_key %0d repeat_key %0d",
               pressed_mask_o, pressed_key_o, clicked_key_o, repeat_key_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (pressed_mask_o !== want.pmask) begin
          $error("pressed_mask: expected %h, got %h", want.pmask, pressed_mask_o);
          fail_count++;
        end
        if (pressed_key_o !== want.pkey) begin
          $error("pressed_key: expected %0d, got %0d", want.pkey, pressed_key_o);
          fail_count++;
        end
        if (clicked_key_o !== want.ckey) begin
          $error("clicked_key: expected %0d, got %0d", want.ckey, clicked_key_o);
          fail_count++;
        end
        if (repeat_key_o !== want.rkey) begin
          $error("repeat_key: expected %0d, got %0d", want.rkey, repeat_key_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_tog != hold_ack) begin
      hold_ack    <= hold_tog;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= stall_on && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register write helpers
  // --------------------------------------------------------------------------

  // One scan transfer; may idle first, holds the payload until accepted.
  // Each cycle idles with the same chance, so gaps take about IdlePct of time.
  task automatic send_scan(input logic [KeyWordW-1:0] keys,
                           input logic [TickInW-1:0]  tick,
                           input logic                clr);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    raw_keys_i     <= keys;
    tick_now_i     <= tick;
    clear_repeat_i <= clr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Leaves cfg_valid_i high so back-to-back writes need no gap; caller lowers.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_delays(input logic [DelayW-1:0] fd, input logic [DelayW-1:0] rd);
    wait_idle();
    write_reg(CfgFirstDelay, fd);
    write_reg(CfgRepeatDelay, rd);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly press/hold/release sessions on one key with ticks
  // landing around the delay thresholds, the rest unstructured noise.
  task automatic run_random(input int unsigned n);
    int unsigned         sent;
    int unsigned         k;
    int unsigned         holds;
    logic [KeyWordW-1:0] word;
    logic [TickInW-1:0]  tick_step;
    logic [DelayW-1:0]   dly;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 20) begin
        send_scan(KeyWordW'($urandom), $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // now and then run close to the tick wrap
        if ($urandom_range(0, 15) == 0)
          tick_base = 32'hFFFF_FFFF - $urandom_range(0, 600);
        k    = $urandom_range(0, NumKeys - 1);
        word = ~KeyMask[k];
        word[KeyWordW-1:NumKeys] = 4'($urandom_range(0, 15));  // unused bits
        if ($urandom_range(0, 3) == 0)
          word &= KeyWordW'($urandom);                      // other keys too
        tick_base += $urandom_range(1, 50);
        send_scan(word, tick_base, $urandom_range(0, 9) == 0);
        holds = $urandom_range(1, 8);
        repeat (holds) begin
          dly = $urandom_range(0, 1) ? first_dly : repeat_dly;
          case ($urandom_range(0, 4))
            0:       tick_step = TickInW'(dly) - 1;
            1:       tick_step = TickInW'(dly);
            2:       tick_step = TickInW'(dly) + 1;
            3:       tick_step = $urandom_range(0, dly);
            default: tick_step = TickInW'(dly) + $urandom_range(2, 40);
          endcase
          tick_base += tick_step;
          if ($urandom_range(0, 7) == 0)
            word[$urandom_range(0, KeyWordW - 1)] ^= 1'b1;
          send_scan(word, tick_base, $urandom_range(0, 11) == 0);
        end
        word = $urandom_range(0, 1) ? KeysReleased : (word | KeyMask[k]);
        send_scan(word, tick_base + $urandom_range(0, 20), 1'b0);
        sent += holds + 2;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk each table key on its own, then all keys down. Key 6 shares bit 0
  // with key 7, so moving from 6 to 7 is a press with no click and drops
  // the held key.
  task automatic test_key_table();
    int unsigned k;
    send_scan(KeysReleased, '0, 1'b0);
    for (k = 0; k < NumKeys; k++)
      send_scan(~KeyMask[k], TickInW'(10 * (k + 1)), 1'b0);
    send_scan('0, 32'hFFFF_FFFF, 1'b0);
  endtask

  // Reset delays (500 then 175): exactly the delay does not fire, one more does.
  task automatic test_repeat_timing();
    logic [KeyWordW-1:0] key5;
    key5 = ~KeyMask[4];
    send_scan(KeysReleased, 32'd1000, 1'b0);
    send_scan(key5, 32'd2000, 1'b0);
    send_scan(key5, 32'd2500, 1'b0);
    send_scan(key5, 32'd2501, 1'b0);
    send_scan(key5, 32'd2676, 1'b0);
    send_scan(key5, 32'd2677, 1'b0);
  endtask

  // Click together with clear still latches the key; elapsed time across the
  // tick wrap; a clear on a held key stops its repeats.
  task automatic test_wrap_and_clear();
    logic [KeyWordW-1:0] key3;
    key3 = ~KeyMask[2];
    send_scan(key3, 32'hFFFF_FF00, 1'b1);
    send_scan(key3, 32'hFFFF_FFFF, 1'b0);
    send_scan(key3, 32'h0000_00F4, 1'b0);
    send_scan(key3, 32'h0000_00F5, 1'b0);
    send_scan(key3, 32'h0000_2000, 1'b1);
    send_scan(key3, 32'h0000_4000, 1'b0);
  endtask

  // Long stretch with neither side idling, reset delays.
  task automatic test_steady_stream();
    wait_idle();
    idle_on  = 1'b0;
    stall_on <= 1'b0;
    run_random(150);
    idle_on  = 1'b1;
    stall_on <= 1'b1;
  endtask

  task automatic test_zero_delays();
    set_delays('0, '0);
    run_random(150);
  endtask

  task automatic test_max_delays();
    set_delays('1, '1);
    run_random(150);
  endtask

  // Writes to the spare indexes must leave both delays alone.
  task automatic test_spare_regs();
    wait_idle();
    write_reg(CfgSpareA, DelayW'($urandom));
    write_reg(CfgSpareB, DelayW'($urandom));
    cfg_valid_i <= 1'b0;
    run_random(100);
  endtask

  // Receiver holds off while the sender keeps offering, so both pipeline
  // stages fill and the input stalls.
  task automatic test_backpressure();
    set_delays(16'd3, 16'd1);
    idle_on  = 1'b0;
    hold_tog <= ~hold_tog;
    run_random(150);
    idle_on  = 1'b1;
  endtask

  // Lopsided extremes, then a random setting.
  task automatic test_mixed_delays();
    set_delays('0, '1);
    run_random(100);
    set_delays('1, '0);
    run_random(100);
    set_delays(DelayW'($urandom_range(0, 2000)), DelayW'($urandom_range(0, 2000)));
    run_random(100);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_key_table();
    test_repeat_timing();
    test_wrap_and_clear();
    test_steady_stream();
    test_zero_delays();
    test_max_delays();
    test_spare_regs();
    test_backpressure();
    test_mixed_delays();

    // drain; the watchdog bounds this
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("tb: %0d scans sent, %0d results compared, %0d register writes",
             scans_taken, results_seen, reg_writes);
    $display("tb: %0d clicks and %0d timed repeats predicted", clicks_seen, repeats_seen);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
